FILE: hw/rtl/gcg_pkg.sv
package gcg_pkg;

    localparam int ENTRIES_DEF = 256;
    localparam int FRAC_BITS   = 30;
    localparam int LOG_W       = 33;
    localparam int DIV_W       = LOG_W + 13;
    localparam int ACC_W       = FRAC_BITS + 1;
    localparam int EXP_STEPS   = FRAC_BITS;
    localparam int V_W         = 50;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAMMA         = 3'd0,
        REG_BRIGHTNESS    = 3'd1,
        REG_CONTRAST      = 3'd2,
        REG_BALANCE_RED   = 3'd3,
        REG_BALANCE_GREEN = 3'd4,
        REG_BALANCE_BLUE  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } ctl_t;

    typedef logic [255:0][LOG_W-1:0]       log_tab_t;
    typedef logic [EXP_STEPS-1:0][ACC_W-1:0] root_tab_t;

    function automatic longint unsigned isqrt64(longint unsigned a_in);
        longint unsigned a;
        longint unsigned res;
        longint unsigned b;
        a   = a_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= res + b)
            begin
                a   = a - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned log2_q30(longint unsigned n);
        longint unsigned e;
        longint unsigned y;
        longint unsigned frac;
        e    = 0;
        frac = 0;
        while (e < 7 && (n >> (e + 1)) != 0)
            e = e + 1;
        y = n << (FRAC_BITS - e);
        for (int k = FRAC_BITS - 1; k >= 0; k--)
        begin
            y = (y * y) >> FRAC_BITS;
            if (y >= (64'd1 << (FRAC_BITS + 1)))
            begin
                frac = frac | (64'd1 << k);
                y    = y >> 1;
            end
        end
        return (e << FRAC_BITS) | frac;
    endfunction

    // log2(255) - log2(i), index zero unused
    function automatic log_tab_t build_log_tab();
        log_tab_t        tab;
        longint unsigned top;
        top    = log2_q30(64'd255);
        tab[0] = '0;
        for (int i = 1; i < 256; i++)
            tab[i] = LOG_W'(top - log2_q30(64'(i)));
        return tab;
    endfunction

    // 2^-(2^-k) in Q30, k = 1..30
    function automatic root_tab_t build_root_tab();
        root_tab_t       tab;
        longint unsigned root;
        root = 64'd1 << (FRAC_BITS - 1);
        for (int k = 0; k < EXP_STEPS; k++)
        begin
            root   = isqrt64(root << FRAC_BITS);
            tab[k] = ACC_W'(root);
        end
        return tab;
    endfunction

    localparam log_tab_t  LOG_TAB  = build_log_tab();
    localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

FILE: hw/rtl/gamma_curve_entry_generator_unit.sv
// Throughput: one entry per cycle while the skid is empty; the 46-stage divider
// and the 30-stage exp2 multiplier chain are fully pipelined.
// An output register plus a one-entry skid; input stalls while the skid is full.
// Reset (rst_n, async, active low) clears all valid bits and loads the
// default registers: gamma 1.0, brightness/contrast/balances 1.0.
module gamma_curve_entry_generator_unit #(
    parameter int ENTRIES = gcg_pkg::ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gcg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       entry_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      red_level,
    output logic [15:0]                      green_level,
    output logic [15:0]                      blue_level
);

    localparam int ACC_W = gcg_pkg::ACC_W;
    localparam int STEPS = gcg_pkg::EXP_STEPS;
    localparam int FB    = gcg_pkg::FRAC_BITS;
    localparam int V_W   = gcg_pkg::V_W;
    localparam logic [7:0] LAST_IDX = 8'(ENTRIES - 1);

    // configuration
    logic [15:0] gamma_reg;
    logic [14:0] brightness_reg;
    logic [14:0] contrast_reg;
    logic [14:0] bal_r_reg;
    logic [14:0] bal_g_reg;
    logic [14:0] bal_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg      <= 16'd8192;
            brightness_reg <= 15'd16384;
            contrast_reg   <= 15'd16384;
            bal_r_reg      <= 15'd16384;
            bal_g_reg      <= 15'd16384;
            bal_b_reg      <= 15'd16384;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gcg_pkg::REG_GAMMA:         gamma_reg      <= cfg_data;
                gcg_pkg::REG_BRIGHTNESS:    brightness_reg <= cfg_data[14:0];
                gcg_pkg::REG_CONTRAST:      contrast_reg   <= cfg_data[14:0];
                gcg_pkg::REG_BALANCE_RED:   bal_r_reg      <= cfg_data[14:0];
                gcg_pkg::REG_BALANCE_GREEN: bal_g_reg      <= cfg_data[14:0];
                gcg_pkg::REG_BALANCE_BLUE:  bal_b_reg      <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic [15:0] gamma_eff;
    logic [15:0] contrast_off;
    logic [31:0] term_k;
    logic signed [15:0] bc_diff;

    assign gamma_eff    = (gamma_reg == '0) ? 16'd1 : gamma_reg;
    assign contrast_off = {1'b0, contrast_reg} + 16'd16384;
    assign term_k       = {contrast_off, 16'd0} - {16'd0, contrast_off};
    assign bc_diff      = $signed({1'b0, brightness_reg}) - $signed({1'b0, contrast_reg});

    // pipeline enable, stalls only when the skid entry is occupied
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // stage 0: clamp and log lookup
    gcg_pkg::ctl_t              s0_ctl_reg;
    logic [gcg_pkg::LOG_W-1:0]  s0_log_reg;
    logic [7:0]                 idx_c;

    assign idx_c = (entry_index > LAST_IDX) ? LAST_IDX : entry_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_ctl_reg <= '0;
        end
        else if (en)
        begin
            s0_ctl_reg.valid <= in_valid;
            s0_ctl_reg.zero  <= idx_c == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_log_reg <= gcg_pkg::LOG_TAB[idx_c];
        end
    end

    gcg_pkg::ctl_t             div_ctl;
    logic [gcg_pkg::DIV_W-1:0] div_q;

    gcg_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (s0_ctl_reg),
        .dividend (s0_log_reg),
        .divisor  (gamma_eff),
        .out_ctl  (div_ctl),
        .quotient (div_q)
    );

    // exp2 chain: stage 0 loads, stages 1..30 multiply by the roots
    gcg_pkg::ctl_t    e_ctl_reg  [STEPS+1];
    logic [ACC_W-1:0] e_acc_reg  [STEPS+1];
    logic [FB-1:0]    e_frac_reg [STEPS+1];
    logic [4:0]       e_n_reg    [STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            e_ctl_reg[0].valid <= div_ctl.valid;
            e_ctl_reg[0].zero  <= div_ctl.zero || (div_q[gcg_pkg::DIV_W-1:FB] >= 16'd31);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_acc_reg[0]  <= ACC_W'(1) << FB;
            e_frac_reg[0] <= div_q[FB-1:0];
            e_n_reg[0]    <= div_q[FB+4:FB];
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_exp
        logic [2*ACC_W-1:0] prod;

        assign prod = e_acc_reg[k-1] * gcg_pkg::ROOT_TAB[k-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                e_ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                e_ctl_reg[k] <= e_ctl_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e_acc_reg[k]  <= e_frac_reg[k-1][FB-k] ? prod[FB+ACC_W-1:FB]
                                                         : e_acc_reg[k-1];
                e_frac_reg[k] <= e_frac_reg[k-1];
                e_n_reg[k]    <= e_n_reg[k-1];
            end
        end
    end

    // power, level product, level sum, channel products
    logic             p_valid_reg;
    logic [ACC_W-1:0] p_reg;
    logic             m1_valid_reg;
    logic [62:0]      m1_prod_reg;
    logic             m2_valid_reg;
    logic signed [V_W-1:0] m2_v_reg;
    logic             c1_valid_reg;
    logic             c1_neg_reg;
    logic [63:0]      c1_r_reg;
    logic [63:0]      c1_g_reg;
    logic [63:0]      c1_b_reg;

    logic signed [V_W-1:0] term_s;
    logic signed [V_W-1:0] offs_s;
    logic [V_W-1:0]        diff_ext;

    assign term_s   = $signed({2'b00, m1_prod_reg[62:15]});
    assign diff_ext = {{(V_W-16){bc_diff[15]}}, bc_diff};
    assign offs_s   = $signed({diff_ext[V_W-FB-1:0], {FB{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg  <= e_ctl_reg[STEPS].valid;
            m1_valid_reg <= p_valid_reg;
            m2_valid_reg <= m1_valid_reg;
            c1_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg       <= e_ctl_reg[STEPS].zero ? '0 : (e_acc_reg[STEPS] >> e_n_reg[STEPS]);
            m1_prod_reg <= {31'd0, term_k} * {32'd0, p_reg};
            m2_v_reg    <= term_s + offs_s;
            c1_neg_reg  <= m2_v_reg[V_W-1] || (m2_v_reg == '0);
            c1_r_reg    <= {15'd0, m2_v_reg[V_W-2:0]} * {49'd0, bal_r_reg};
            c1_g_reg    <= {15'd0, m2_v_reg[V_W-2:0]} * {49'd0, bal_g_reg};
            c1_b_reg    <= {15'd0, m2_v_reg[V_W-2:0]} * {49'd0, bal_b_reg};
        end
    end

    logic [15:0] sat_r;
    logic [15:0] sat_g;
    logic [15:0] sat_b;

    assign sat_r = c1_neg_reg ? 16'd0 : (|c1_r_reg[63:60] ? 16'hFFFF : c1_r_reg[59:44]);
    assign sat_g = c1_neg_reg ? 16'd0 : (|c1_g_reg[63:60] ? 16'hFFFF : c1_g_reg[59:44]);
    assign sat_b = c1_neg_reg ? 16'd0 : (|c1_b_reg[63:60] ? 16'hFFFF : c1_b_reg[59:44]);

    // output register and skid
    logic        out_valid_reg;
    logic [15:0] out_r_reg;
    logic [15:0] out_g_reg;
    logic [15:0] out_b_reg;
    logic [15:0] skid_r_reg;
    logic [15:0] skid_g_reg;
    logic [15:0] skid_b_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || c1_valid_reg;
            skid_valid_reg <= 1'b0;
        end
        else if (c1_valid_reg && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_r_reg <= skid_r_reg;
                out_g_reg <= skid_g_reg;
                out_b_reg <= skid_b_reg;
            end
            else
            begin
                out_r_reg <= sat_r;
                out_g_reg <= sat_g;
                out_b_reg <= sat_b;
            end
        end
        else if (en)
        begin
            skid_r_reg <= sat_r;
            skid_g_reg <= sat_g;
            skid_b_reg <= sat_b;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_level   = out_r_reg;
    assign green_level = out_g_reg;
    assign blue_level  = out_b_reg;

endmodule

FILE: hw/rtl/gcg_div_pipe.sv
module gcg_div_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  gcg_pkg::ctl_t               in_ctl,
    input  logic [gcg_pkg::LOG_W-1:0]   dividend,
    input  logic [15:0]                 divisor,
    output gcg_pkg::ctl_t               out_ctl,
    output logic [gcg_pkg::DIV_W-1:0]   quotient
);

    localparam int N = gcg_pkg::DIV_W;
    localparam int LW = gcg_pkg::LOG_W;

    gcg_pkg::ctl_t     ctl_reg [N];
    logic [15:0]       rem_reg [N];
    logic [LW-1:0]     num_reg [N];
    logic [N-1:0]      q_reg   [N];

    // restoring division of {dividend, 13'b0}, one quotient bit per stage
    for (genvar j = 0; j < N; j++)
    begin : g_stage
        gcg_pkg::ctl_t ctl_prev;
        logic [15:0]   rem_prev;
        logic [LW-1:0] num_prev;
        logic [N-1:0]  q_prev;
        logic [16:0]   trial;
        logic          ge;
        logic [16:0]   diff;

        if (j == 0)
        begin : g_first
            assign ctl_prev = in_ctl;
            assign rem_prev = '0;
            assign num_prev = dividend;
            assign q_prev   = '0;
        end
        else
        begin : g_next
            assign ctl_prev = ctl_reg[j-1];
            assign rem_prev = rem_reg[j-1];
            assign num_prev = num_reg[j-1];
            assign q_prev   = q_reg[j-1];
        end

        assign trial = {rem_prev, num_prev[LW-1]};
        assign ge    = trial >= {1'b0, divisor};
        assign diff  = trial - {1'b0, divisor};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else if (en)
            begin
                ctl_reg[j] <= ctl_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? diff[15:0] : trial[15:0];
                num_reg[j] <= {num_prev[LW-2:0], 1'b0};
                q_reg[j]   <= {q_prev[N-2:0], ge};
            end
        end
    end

    assign out_ctl  = ctl_reg[N-1];
    assign quotient = q_reg[N-1];

endmodule

FILE: hw/rtl/gcg_checker.sv
module gcg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_ready,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [15:0]                     red_level,
    input logic [15:0]                     green_level,
    input logic [15:0]                     blue_level
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_level)
            && $stable(green_level) && $stable(blue_level))
        else $error("output changed during stall");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config write refused");

    a_block_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with no pending result");

    a_block_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input blocked without output stall");

endmodule

bind gamma_curve_entry_generator_unit gcg_checker u_gcg_checker (.*);

FILE: test/tb_gamma_curve_entry_generator_unit.sv
`timescale 1ns / 1ps

module tb_gamma_curve_entry_generator_unit;

    localparam int PIPE_WAIT   = 90;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } ramp_entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [gcg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gcg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  entry_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;

    // shadow copy of the block's registers
    logic [15:0] sh_gamma;
    logic [14:0] sh_bright;
    logic [14:0] sh_contrast;
    logic [14:0] sh_bal_r;
    logic [14:0] sh_bal_g;
    logic [14:0] sh_bal_b;

    ramp_entry_t pending_levels[$];
    int          errors = 0;
    int          checked = 0;
    int          sent = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    gamma_curve_entry_generator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .entry_index(entry_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_level(red_level), .green_level(green_level), .blue_level(blue_level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned a_in);
        longint unsigned a;
        longint unsigned r;
        longint unsigned b;
        a = a_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned log2_fix(longint unsigned n);
        longint unsigned ex;
        longint unsigned y;
        longint unsigned fr;
        ex = 0;
        fr = 0;
        while (ex < 7 && (n >> (ex + 1)) != 0)
            ex = ex + 1;
        y = n << (30 - ex);
        for (int k = 29; k >= 0; k--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31))
            begin
                fr = fr | (64'd1 << k);
                y = y >> 1;
            end
        end
        return (ex << 30) | fr;
    endfunction

    function automatic longint unsigned neg_exp2_fix(longint unsigned f);
        longint unsigned rt;
        longint unsigned acc;
        rt = 64'd1 << 29;
        acc = 64'd1 << 30;
        for (int k = 1; k <= 30; k++)
        begin
            rt = int_sqrt(rt << 30);
            if ((f >> (30 - k)) & 1)
                acc = (acc * rt) >> 30;
        end
        return acc;
    endfunction

    function automatic logic [15:0] sat_channel(longint unsigned lvl, logic [14:0] bal);
        longint unsigned q;
        q = (lvl * bal) >> 44;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic ramp_entry_t predict_levels(logic [7:0] idx);
        longint unsigned g;
        longint unsigned pw;
        longint unsigned dl;
        longint unsigned t;
        longint unsigned sh;
        longint unsigned term;
        longint          lvl;
        ramp_entry_t     e;
        g = (sh_gamma != 0) ? sh_gamma : 1;
        pw = 0;
        if (idx != 0)
        begin
            dl = log2_fix(255) - log2_fix(idx);
            t = (dl * 8192) / g;
            sh = t >> 30;
            if (sh < 31)
                pw = neg_exp2_fix(t & ((64'd1 << 30) - 1)) >> sh;
        end
        term = ((longint'(sh_contrast) + 16384) * 65535 * pw) >> 15;
        lvl = longint'(term) + (longint'(sh_bright) - longint'(sh_contrast)) * (64'sd1 << 30);
        if (lvl <= 0)
        begin
            e.red = 0;
            e.green = 0;
            e.blue = 0;
        end
        else
        begin
            e.red = sat_channel(lvl, sh_bal_r);
            e.green = sat_channel(lvl, sh_bal_g);
            e.blue = sat_channel(lvl, sh_bal_b);
        end
        return e;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH %s at cycle %0d", msg, cycles);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (recv_idle_pct > 0)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        else
            out_ready <= 1'b1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                report_mismatch("unexpected ramp entry");
            end
            else
            begin
                ramp_entry_t e;
                e = pending_levels.pop_front();
                checked++;
                if (red_level !== e.red)
                    report_mismatch($sformatf("red: got %0d expected %0d",
                                              red_level, e.red));
                if (green_level !== e.green)
                    report_mismatch($sformatf("green: got %0d expected %0d",
                                              green_level, e.green));
                if (blue_level !== e.blue)
                    report_mismatch($sformatf("blue: got %0d expected %0d",
                                              blue_level, e.blue));
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d entries outstanding", pending_levels.size());
            $display("tb_gamma_curve_entry_generator_unit: done, errors");
            $finish;
        end
    end

    task automatic send_entry(logic [7:0] idx);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        entry_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        pending_levels.push_back(predict_levels(idx));
        sent++;
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (PIPE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(gcg_pkg::cfg_reg_t r, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (r)
            gcg_pkg::REG_GAMMA:         sh_gamma = d;
            gcg_pkg::REG_BRIGHTNESS:    sh_bright = d[14:0];
            gcg_pkg::REG_CONTRAST:      sh_contrast = d[14:0];
            gcg_pkg::REG_BALANCE_RED:   sh_bal_r = d[14:0];
            gcg_pkg::REG_BALANCE_GREEN: sh_bal_g = d[14:0];
            gcg_pkg::REG_BALANCE_BLUE:  sh_bal_b = d[14:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_regs(logic [15:0] g, logic [15:0] b, logic [15:0] c,
                             logic [15:0] r, logic [15:0] gr, logic [15:0] bl);
        write_reg(gcg_pkg::REG_GAMMA, g);
        write_reg(gcg_pkg::REG_BRIGHTNESS, b);
        write_reg(gcg_pkg::REG_CONTRAST, c);
        write_reg(gcg_pkg::REG_BALANCE_RED, r);
        write_reg(gcg_pkg::REG_BALANCE_GREEN, gr);
        write_reg(gcg_pkg::REG_BALANCE_BLUE, bl);
    endtask

    task automatic test_defaults();
        logic [7:0] pts[10] = '{8'd0, 8'd1, 8'd2, 8'd85, 8'd127, 8'd128,
                                8'd170, 8'd254, 8'd255, 8'd64};
        foreach (pts[i])
            send_entry(pts[i]);
        drain_pipe();
    endtask

    task automatic test_extremes();
        // zero gamma, saturating gains
        load_regs(16'd0, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h4000);
        send_entry(8'd0);
        send_entry(8'd128);
        send_entry(8'd255);
        drain_pipe();
        // largest gamma, negative level, full contrast
        load_regs(16'hFFFF, 16'h0000, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h7FFF);
        send_entry(8'd0);
        send_entry(8'd1);
        send_entry(8'd200);
        send_entry(8'd255);
        drain_pipe();
        // tiny gamma with default levels
        load_regs(16'd1, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_entry(8'd1);
        send_entry(8'd254);
        send_entry(8'd255);
        drain_pipe();
    endtask

    task automatic test_random(int n_sets, int per_set);
        for (int s = 0; s < n_sets; s++)
        begin
            if ($urandom_range(3) == 0)
                write_reg(gcg_pkg::REG_GAMMA, 16'($urandom_range(65535)));
            else
                write_reg(gcg_pkg::REG_GAMMA, 16'($urandom_range(2048, 24576)));
            write_reg(gcg_pkg::REG_BRIGHTNESS, 16'($urandom_range(65535)));
            write_reg(gcg_pkg::REG_CONTRAST, 16'($urandom_range(65535)));
            write_reg(gcg_pkg::REG_BALANCE_RED, 16'($urandom_range(65535)));
            write_reg(gcg_pkg::REG_BALANCE_GREEN, 16'($urandom_range(65535)));
            write_reg(gcg_pkg::REG_BALANCE_BLUE, 16'($urandom_range(65535)));
            for (int i = 0; i < per_set; i++)
                send_entry(8'($urandom_range(255)));
            drain_pipe();
        end
    endtask

    initial
    begin
        sh_gamma = 16'd8192;
        sh_bright = 15'd16384;
        sh_contrast = 15'd16384;
        sh_bal_r = 15'd16384;
        sh_bal_g = 15'd16384;
        sh_bal_b = 15'd16384;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_extremes();
        send_idle_pct = 33;
        recv_idle_pct = 49;
        test_random(7, 50);
        send_idle_pct = 49;
        recv_idle_pct = 33;
        test_random(7, 50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(7, 50);
        drain_pipe();
        $display("covered %0d entries, %0d checked, across reset, extreme and random settings",
                 sent, checked);
        $display("including zero gamma, saturation, negative levels and both idle mixes");
        if (errors == 0)
            $display("tb_gamma_curve_entry_generator_unit: done, clean");
        else
            $display("tb_gamma_curve_entry_generator_unit: done, errors");
        $finish;
    end

endmodule
